### rtl/tiue_pkg.sv
package tiue_pkg;

	localparam logic [7:0] MAX_NAME_LEN_RESET = 8'd255;
	localparam logic [7:0] CONTENT_MAX        = 8'd255;

	localparam logic [7:0] CMD_IAC  = 8'd255;
	localparam logic [7:0] CMD_SB   = 8'd250;
	localparam logic [7:0] CMD_WILL = 8'd251;
	localparam logic [7:0] CMD_DONT = 8'd254;
	localparam logic [7:0] OPT_NEW_ENVIRON = 8'h27;

	localparam logic [2:0] PAT_LEN = 3'd6;

	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_IAC,
		PH_OPTSKIP,
		PH_SBOPT,
		PH_SB_ENV,
		PH_SB_OTHER,
		PH_SBIAC_ENV,
		PH_SBIAC_OTHER
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] pattern_matched;
		logic [7:0] content_count;
		logic [7:0] name_count;
		logic [7:0] held_byte;
		logic       held_valid;
		logic       collecting;
		logic       name_done;
	} state_t;

	typedef struct packed {
		logic [7:0] name_byte;
		logic       byte_valid;
		logic       name_end;
	} result_t;

	// Results of one input byte, at most two; r1 is used only together with r0.
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

	typedef struct packed {
		state_t  s;
		logic    emit;
		result_t r;
	} take_t;

	function automatic logic [7:0] user_pat(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h00;
			3'd1: c = 8'h55;
			3'd2: c = 8'h53;
			3'd3: c = 8'h45;
			3'd4: c = 8'h52;
			3'd5: c = 8'h01;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic state_t clear_match(input state_t s);
		state_t n;
		n = s;
		n.pattern_matched = '0;
		n.content_count   = '0;
		n.name_count      = '0;
		n.held_byte       = '0;
		n.held_valid      = 1'b0;
		n.collecting      = 1'b0;
		n.name_done       = 1'b0;
		return n;
	endfunction

	function automatic take_t end_name(input state_t s);
		take_t t;
		t.s    = s;
		t.emit = 1'b0;
		t.r    = '0;
		if (s.collecting && !s.name_done) begin
			t.emit         = 1'b1;
			t.r.name_byte  = s.held_valid ? s.held_byte : 8'd0;
			t.r.byte_valid = s.held_valid;
			t.r.name_end   = 1'b1;
			t.s.name_done  = 1'b1;
		end
		t.s.collecting = 1'b0;
		t.s.held_valid = 1'b0;
		t.s.held_byte  = '0;
		return t;
	endfunction

	function automatic state_t command(input state_t s, input logic [7:0] b);
		state_t n;
		n = s;
		if (b == CMD_SB) begin
			n = clear_match(s);
			n.phase = PH_SBOPT;
		end else if (b inside {[CMD_WILL:CMD_DONT]}) begin
			n.phase = PH_OPTSKIP;
		end else begin
			n.phase = PH_NORMAL;
		end
		return n;
	endfunction

	function automatic take_t take_content(input state_t s, input logic [7:0] b,
			input logic [7:0] max_len);
		take_t t;
		logic  col;
		t.s    = s;
		t.emit = 1'b0;
		t.r    = '0;
		col    = s.collecting || (s.pattern_matched == PAT_LEN);
		if (s.content_count < CONTENT_MAX) begin
			t.s.content_count = s.content_count + 8'd1;
			if (!s.name_done) begin
				t.s.collecting = col;
				if (col) begin
					if (b == 8'd0 || b == 8'd1) begin
						t = end_name(t.s);
					end else if (s.name_count < max_len) begin
						if (s.held_valid) begin
							t.emit         = 1'b1;
							t.r.name_byte  = s.held_byte;
							t.r.byte_valid = 1'b1;
							t.r.name_end   = 1'b0;
						end
						t.s.held_byte  = b;
						t.s.held_valid = 1'b1;
						t.s.name_count = s.name_count + 8'd1;
					end
				end else if (s.content_count != 8'd0) begin
					// The first content byte is the IS code and is not searched.
					if (b == user_pat(s.pattern_matched)) begin
						t.s.pattern_matched = s.pattern_matched + 3'd1;
					end else if (b == 8'd0) begin
						t.s.pattern_matched = 3'd1;
					end else begin
						t.s.pattern_matched = 3'd0;
					end
				end
			end
		end
		return t;
	endfunction

endpackage

### rtl/telnet_iac_user_extractor.sv
// Extracts the USER value of a NEW-ENVIRON subnegotiation from a client
// telnet packet that arrives one byte per word on the input channel.
// Input channel: data_byte and end_of_packet, taken when in_valid is high
// and in_stall is low. end_of_packet marks the last byte of a packet, and
// the parser returns to plain data after it.
// Output channel: name_byte, byte_valid and name_end, taken when out_valid
// is high and out_stall is low. Name bytes come out in order; the last word
// of a name has name_end set, and an empty name gives one word with
// byte_valid low.
// The user must write max_name_len through cfg_valid/cfg_ready only while
// idle; the block does not enforce this, and cfg_ready is always high.
// An accepted byte is registered in the input stage; its results are queued.
// One byte is accepted per cycle; the parser stage waits while the four-word
// result queue has room for fewer than two words, so in_stall rises only
// when the receiver stalls until that queue has fewer than two free words.
// Reset clears the parser to plain data, empties the queue and sets
// max_name_len to 255.
module telnet_iac_user_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_packet,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] max_name_len,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] name_byte,
	output logic       byte_valid,
	output logic       name_end
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              eop_s1;
	logic [7:0]        max_len_q;
	tiue_pkg::state_t  state_q;
	tiue_pkg::state_t  state_next;
	tiue_pkg::push_t   push_raw;
	tiue_pkg::push_t   push;
	tiue_pkg::result_t head;
	logic              room;
	logic              advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			data_s1 <= data_byte;
			eop_s1  <= end_of_packet;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			max_len_q <= tiue_pkg::MAX_NAME_LEN_RESET;
			state_q   <= '0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (cfg_valid) max_len_q <= max_name_len;
			if (advance) state_q <= state_next;
		end
	end

	tiue_step u_step (
		.st      (state_q),
		.data    (data_s1),
		.eop     (eop_s1),
		.max_len (max_len_q),
		.st_next (state_next),
		.push    (push_raw)
	);

	always_comb begin
		push    = push_raw;
		push.v0 = push_raw.v0 && advance;
		push.v1 = push_raw.v1 && advance;
	end

	tiue_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign name_byte  = head.name_byte;
	assign byte_valid = head.byte_valid;
	assign name_end   = head.name_end;

endmodule

### rtl/tiue_step.sv
module tiue_step (
	input  tiue_pkg::state_t st,
	input  logic [7:0]       data,
	input  logic             eop,
	input  logic [7:0]       max_len,
	output tiue_pkg::state_t st_next,
	output tiue_pkg::push_t  push
);

	always_comb begin
		tiue_pkg::state_t s;
		tiue_pkg::take_t  t;
		tiue_pkg::push_t  p;
		s = st;
		p = '0;
		t = '0;

		case (st.phase)
			tiue_pkg::PH_NORMAL: begin
				if (data == tiue_pkg::CMD_IAC) s.phase = tiue_pkg::PH_IAC;
			end
			tiue_pkg::PH_IAC: begin
				s = tiue_pkg::command(s, data);
			end
			tiue_pkg::PH_OPTSKIP: begin
				s.phase = tiue_pkg::PH_NORMAL;
			end
			tiue_pkg::PH_SBOPT: begin
				if (data == tiue_pkg::CMD_IAC) s.phase = tiue_pkg::PH_SBIAC_OTHER;
				else if (data == tiue_pkg::OPT_NEW_ENVIRON) s.phase = tiue_pkg::PH_SB_ENV;
				else s.phase = tiue_pkg::PH_SB_OTHER;
			end
			tiue_pkg::PH_SB_ENV: begin
				if (data == tiue_pkg::CMD_IAC) begin
					s.phase = tiue_pkg::PH_SBIAC_ENV;
				end else if (!eop) begin
					t = tiue_pkg::take_content(s, data, max_len);
					s = t.s;
					p.v0 = t.emit;
					p.r0 = t.r;
				end
			end
			tiue_pkg::PH_SB_OTHER: begin
				if (data == tiue_pkg::CMD_IAC) s.phase = tiue_pkg::PH_SBIAC_OTHER;
			end
			tiue_pkg::PH_SBIAC_ENV: begin
				if (data == tiue_pkg::CMD_IAC) begin
					// A doubled IAC is two 255 content bytes, the second dropped on the last byte.
					t = tiue_pkg::take_content(s, tiue_pkg::CMD_IAC, max_len);
					s = t.s;
					p.v0 = t.emit;
					p.r0 = t.r;
					if (!eop) begin
						t = tiue_pkg::take_content(s, tiue_pkg::CMD_IAC, max_len);
						s = t.s;
						if (t.emit) begin
							if (p.v0) begin
								p.v1 = 1'b1;
								p.r1 = t.r;
							end else begin
								p.v0 = 1'b1;
								p.r0 = t.r;
							end
						end
					end
					s.phase = tiue_pkg::PH_SB_ENV;
				end else begin
					t = tiue_pkg::end_name(s);
					s = tiue_pkg::command(t.s, data);
					p.v0 = t.emit;
					p.r0 = t.r;
				end
			end
			default: begin
				if (data == tiue_pkg::CMD_IAC) s.phase = tiue_pkg::PH_SB_OTHER;
				else s = tiue_pkg::command(s, data);
			end
		endcase

		if (eop) begin
			if (s.phase == tiue_pkg::PH_SB_ENV || s.phase == tiue_pkg::PH_SBIAC_ENV) begin
				t = tiue_pkg::end_name(s);
				s = t.s;
				if (t.emit) begin
					if (p.v0) begin
						p.v1 = 1'b1;
						p.r1 = t.r;
					end else begin
						p.v0 = 1'b1;
						p.r0 = t.r;
					end
				end
			end
			s = tiue_pkg::clear_match(s);
			s.phase = tiue_pkg::PH_NORMAL;
		end

		st_next = s;
		push    = p;
	end

endmodule

### rtl/tiue_outq.sv
module tiue_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  tiue_pkg::push_t   push,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output tiue_pkg::result_t head
);

	tiue_pkg::result_t entry_q [4];
	logic [1:0] head_q;
	logic [1:0] tail_q;
	logic [2:0] count_q;
	logic       pop;
	logic [2:0] push_n;

	// Room for the two words that one input byte can produce at most.
	assign room      = (count_q <= 3'd2);
	assign out_valid = (count_q != 3'd0);
	assign head      = entry_q[head_q];
	assign pop       = out_valid && !out_stall;
	assign push_n    = {2'b00, push.v0} + {2'b00, push.v1};

	always_ff @(posedge clk) begin
		if (push.v0) entry_q[tail_q] <= push.r0;
		if (push.v1) entry_q[tail_q + 2'd1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) head_q <= head_q + 2'd1;
			tail_q  <= tail_q + push_n[1:0];
			count_q <= count_q + push_n - {2'b00, pop};
		end
	end

endmodule

### tb/telnet_iac_user_extractor_tb.sv
import tiue_pkg::*;

// The USER tag that opens a name inside NEW-ENVIRON content.
localparam logic [47:0] USER_TAG = 48'h00_55_53_45_52_01;
localparam logic [7:0] CMD_SE = 8'd240;
localparam logic [7:0] ENV_IS = 8'd0;

function automatic logic [7:0] tag_byte(input int idx);
	return USER_TAG[8 * (5 - idx) +: 8];
endfunction

class name_scoreboard;
	result_t    expected_words[$];
	int         errors;
	logic [7:0] max_len;
	phase_t     phase;
	logic [2:0] matched;
	logic [7:0] content_cnt;
	logic [7:0] name_cnt;
	logic [7:0] held;
	logic       held_ok;
	logic       collecting;
	logic       done;
	int         step_words;

	function new();
		errors  = 0;
		max_len = MAX_NAME_LEN_RESET;
		phase   = PH_NORMAL;
		restart_sb();
	endfunction

	function void set_max_len(input logic [7:0] v);
		max_len = v;
	endfunction

	function void add_word(input logic [7:0] b, input logic v, input logic e);
		result_t w;
		if (step_words >= 2) return;
		w.name_byte  = b;
		w.byte_valid = v;
		w.name_end   = e;
		expected_words.push_back(w);
		step_words++;
	endfunction

	function void restart_sb();
		matched     = '0;
		content_cnt = '0;
		name_cnt    = '0;
		held        = '0;
		held_ok     = 1'b0;
		collecting  = 1'b0;
		done        = 1'b0;
	endfunction

	function void finish_name();
		if (collecting && !done) begin
			add_word(held_ok ? held : 8'd0, held_ok, 1'b1);
			done = 1'b1;
		end
		collecting = 1'b0;
		held_ok    = 1'b0;
		held       = '0;
	endfunction

	function void take_command(input logic [7:0] b);
		if (b == CMD_SB) begin
			phase = PH_SBOPT;
			restart_sb();
		end else if (b >= CMD_WILL && b <= CMD_DONT) begin
			phase = PH_OPTSKIP;
		end else begin
			phase = PH_NORMAL;
		end
	endfunction

	function void take_env_byte(input logic [7:0] b);
		logic [7:0] idx;
		if (content_cnt >= CONTENT_MAX) return;
		idx = content_cnt;
		content_cnt++;
		if (done) return;
		if (!collecting && matched == PAT_LEN) collecting = 1'b1;
		if (collecting) begin
			if (b == 8'd0 || b == 8'd1) begin
				finish_name();
			end else if (name_cnt < max_len) begin
				// Each name byte waits for the next so the last can carry name_end.
				if (held_ok) add_word(held, 1'b1, 1'b0);
				held    = b;
				held_ok = 1'b1;
				name_cnt++;
			end
			return;
		end
		// The IS code at the head of the content is never searched.
		if (idx == 8'd0) return;
		if (b == tag_byte(matched)) matched++;
		else if (b == 8'd0) matched = 3'd1;
		else matched = 3'd0;
	endfunction

	function void note_byte(input logic [7:0] b, input logic eop);
		step_words = 0;
		case (phase)
			PH_NORMAL: if (b == CMD_IAC) phase = PH_IAC;
			PH_IAC: take_command(b);
			PH_OPTSKIP: phase = PH_NORMAL;
			PH_SBOPT: begin
				if (b == CMD_IAC) phase = PH_SBIAC_OTHER;
				else if (b == OPT_NEW_ENVIRON) phase = PH_SB_ENV;
				else phase = PH_SB_OTHER;
			end
			PH_SB_ENV: begin
				if (b == CMD_IAC) phase = PH_SBIAC_ENV;
				else if (!eop) take_env_byte(b);
			end
			PH_SB_OTHER: if (b == CMD_IAC) phase = PH_SBIAC_OTHER;
			PH_SBIAC_ENV: begin
				if (b == CMD_IAC) begin
					take_env_byte(CMD_IAC);
					if (!eop) take_env_byte(CMD_IAC);
					phase = PH_SB_ENV;
				end else begin
					finish_name();
					take_command(b);
				end
			end
			default: begin
				if (b == CMD_IAC) phase = PH_SB_OTHER;
				else take_command(b);
			end
		endcase
		if (eop) begin
			if (phase == PH_SB_ENV || phase == PH_SBIAC_ENV) finish_name();
			phase = PH_NORMAL;
			restart_sb();
		end
	endfunction

	function void check_word(input logic [7:0] nb, input logic bv, input logic ne);
		result_t w;
		if (expected_words.size() == 0) begin
			$error("unexpected word: name_byte=%0h byte_valid=%0b name_end=%0b", nb, bv, ne);
			errors++;
			return;
		end
		w = expected_words.pop_front();
		if (nb !== w.name_byte) begin
			$error("name_byte: expected %0h, actual %0h", w.name_byte, nb);
			errors++;
		end
		if (bv !== w.byte_valid) begin
			$error("byte_valid: expected %0b, actual %0b", w.byte_valid, bv);
			errors++;
		end
		if (ne !== w.name_end) begin
			$error("name_end: expected %0b, actual %0b", w.name_end, ne);
			errors++;
		end
	endfunction
endclass

module telnet_iac_user_extractor_tb;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = '0;
	logic       end_of_packet = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] max_name_len = MAX_NAME_LEN_RESET;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] name_byte;
	logic       byte_valid;
	logic       name_end;

	name_scoreboard names;
	logic [7:0]     pkt[$];
	logic [7:0]     len_settings[8];
	int             burst_left = 0;
	int             env_items = 0;
	int             stall_left = 0;
	int             stall_tick = 0;
	stall_mode_t    stall_mode = STALL_NONE;

	telnet_iac_user_extractor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.max_name_len  (max_name_len),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.name_byte     (name_byte),
		.byte_valid    (byte_valid),
		.name_end      (name_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 160);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((stall_tick % 7) < 3);
		endcase
	end

	// Outputs are settled by the falling edge, so a word seen here is taken at the next rise.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) names.check_word(name_byte, byte_valid, name_end);
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic eop);
		logic taken;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 64);
		end
		in_valid      <= 1'b1;
		data_byte     <= b;
		end_of_packet <= eop;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (!in_stall) begin
				taken = 1'b1;
				names.note_byte(b, eop);
			end
			@(posedge clk);
		end
		burst_left--;
	endtask

	task automatic send_packet(input logic counts);
		for (int i = 0; i < pkt.size(); i++) begin
			send_byte(pkt[i], i == pkt.size() - 1);
			if (counts) env_items++;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (names.expected_words.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [7:0] v);
		logic ok;
		cfg_valid    <= 1'b1;
		max_name_len <= v;
		ok = 1'b0;
		while (!ok) begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		names.set_max_len(v);
	endtask

	// A 255 inside subnegotiation content has to be doubled on the wire.
	function automatic void put_content(input logic [7:0] b);
		pkt.push_back(b);
		if (b == CMD_IAC) pkt.push_back(b);
	endfunction

	function automatic logic [7:0] pick_content();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'h01;
			2: return tag_byte($urandom_range(1, 4));
			3: return CMD_IAC;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void add_noise(input int n);
		repeat (n) begin
			case ($urandom_range(0, 7))
				0: begin
					pkt.push_back(CMD_IAC);
					pkt.push_back(CMD_IAC);
				end
				1: begin
					pkt.push_back(CMD_IAC);
					pkt.push_back(8'($urandom_range(CMD_WILL, CMD_DONT)));
					pkt.push_back(8'($urandom));
				end
				2: begin
					pkt.push_back(CMD_IAC);
					pkt.push_back(($urandom_range(0, 1) == 0) ? CMD_SE : 8'($urandom_range(0, 249)));
				end
				3: begin
					pkt.push_back(CMD_IAC);
					pkt.push_back(CMD_SB);
					pkt.push_back(($urandom_range(0, 3) == 0) ? CMD_IAC : 8'($urandom_range(0, 38)));
					repeat ($urandom_range(0, 6)) put_content(8'($urandom));
					pkt.push_back(CMD_IAC);
					pkt.push_back(CMD_SE);
				end
				default: pkt.push_back(8'($urandom));
			endcase
		end
	endfunction

	function automatic void build_env_packet();
		int n;
		int cut;
		pkt.delete();
		if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 4));
		pkt.push_back(CMD_IAC);
		pkt.push_back(CMD_SB);
		pkt.push_back(OPT_NEW_ENVIRON);
		if ($urandom_range(0, 5) != 0) pkt.push_back(ENV_IS);
		else put_content(pick_content());
		repeat ($urandom_range(0, 5)) put_content(pick_content());
		if ($urandom_range(0, 7) != 0) begin
			cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 6;
			for (int i = 0; i < cut; i++) pkt.push_back(tag_byte(i));
		end
		// Now and then a name long enough to run into the content limit.
		n = ($urandom_range(0, 39) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 12);
		repeat (n) put_content(($urandom_range(0, 9) == 0) ? pick_content()
			: 8'($urandom_range(2, 254)));
		if ($urandom_range(0, 3) == 0) put_content(8'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0) begin
			if ($urandom_range(0, 1) == 0)
				for (int i = 0; i < 6; i++) pkt.push_back(tag_byte(i));
			repeat ($urandom_range(1, 10)) put_content(pick_content());
		end
		case ($urandom_range(0, 7))
			0: ;
			1: pkt.push_back(CMD_IAC);
			2: begin
				pkt.push_back(CMD_IAC);
				pkt.push_back(8'($urandom));
			end
			default: begin
				pkt.push_back(CMD_IAC);
				pkt.push_back(CMD_SE);
			end
		endcase
		if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 6));
		if ($urandom_range(0, 4) == 0) begin
			cut = $urandom_range(1, pkt.size());
			while (pkt.size() > cut) void'(pkt.pop_back());
		end
	endfunction

	initial begin
		names = new();
		len_settings = '{8'd1, 8'd255, 8'd3, 8'($urandom_range(2, 12)), 8'd1,
			8'($urandom_range(1, 255)), 8'd255, 8'($urandom_range(4, 40))};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Doubled IAC, plain data, WILL with its option, an unknown command.
		pkt = '{8'hFF, 8'hFF, 8'h41, 8'hFF, CMD_WILL, 8'h27, 8'hFF, 8'h7F};
		send_packet(1'b0);
		// A full NEW-ENVIRON IS with a user name that holds two 255 bytes.
		pkt = '{CMD_IAC, CMD_SB, OPT_NEW_ENVIRON, ENV_IS, 8'h00, 8'h55, 8'h53, 8'h45,
			8'h52, 8'h01, 8'h80, 8'hFF, 8'hFF, 8'h01, CMD_IAC, CMD_SE};
		send_packet(1'b0);

		for (int p = 0; p < 8; p++) begin
			drain();
			write_max_len(len_settings[p]);
			while (env_items < (p + 1) * 200) begin
				if ($urandom_range(0, 9) < 7) begin
					build_env_packet();
					send_packet(1'b1);
				end else begin
					pkt.delete();
					add_noise($urandom_range(1, 8));
					send_packet(1'b0);
				end
			end
		end

		drain();
		if (names.errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
rtl/tiue_pkg.sv
rtl/tiue_step.sv
rtl/tiue_outq.sv
rtl/telnet_iac_user_extractor.sv
tb/telnet_iac_user_extractor_tb.sv
